/* rtl/core/task_runtime_accounting_table_defines.svh */
// Assertion macros used by the checker of the task run time accounting table.
`ifndef TASK_RUNTIME_ACCOUNTING_TABLE_DEFINES_SVH
`define TASK_RUNTIME_ACCOUNTING_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/trat_pkg.sv */
package trat_pkg;

  localparam int TASK_W     = 16;
  localparam int TIME_W     = 64;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 5;
  localparam int COUNT_W    = 6;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 80;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_START  = 2'd0;
  localparam cmd_t CMD_STOP   = 2'd1;
  localparam cmd_t CMD_SWITCH = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SUB,
    S_ADD,
    S_DONE
  } state_t;

  // One slot of the table as held in memory.
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] runtime;
    logic [TIME_W-1:0] start;
  } entry_t;

endpackage

/* rtl/core/trat_slot_mem.sv */
// Slot store: one write port, one registered read port. An entry that has
// not been written since reset reads as its reset contents (id equal to the
// slot index, zero run time, zero start time).
module trat_slot_mem #(
  parameter int SLOTS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [$clog2(SLOTS)-1:0]   waddr,
  input  trat_pkg::entry_t           wdata,
  input  logic [$clog2(SLOTS)-1:0]   raddr,
  output trat_pkg::entry_t           rdata
);

  localparam int IW = $clog2(SLOTS);

  trat_pkg::entry_t mem [SLOTS];
  logic [SLOTS-1:0] written_r;
  trat_pkg::entry_t rd_r;
  logic             rd_written_r;
  logic [IW-1:0]    rd_addr_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r      <= mem[raddr];
    rd_addr_r <= raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (we) begin
        written_r[waddr] <= 1'b1;
      end
      rd_written_r <= written_r[raddr];
    end
  end

  always_comb begin
    if (rd_written_r) begin
      rdata = rd_r;
    end else begin
      rdata.task_id = trat_pkg::TASK_W'(rd_addr_r);
      rdata.runtime = '0;
      rdata.start   = '0;
    end
  end

endmodule

/* rtl/core/task_runtime_accounting_table.sv */
// Per-task run time accounting table. Each of SLOTS slots holds a valid mark,
// a 16-bit task id, the accumulated run time and the start time of the
// current run. After reset the first STATIC_TASKS slots are valid with ids
// 0 upward. A start word claims the first free slot from index 1; a stop word
// frees the first valid slot from index 1 whose id matches; a switch word adds
// (timestamp - start time) modulo 2^64 to the outgoing task's run time and
// sets the incoming task's start time to the timestamp. Every input word
// yields exactly one result word. The block works on one word at a time: a
// small sequencer walks the slots one by one through a slot memory with one
// write port and one registered read port, addressing each slot (S_READ) and
// then comparing it (S_CHECK); each run time update uses the one shared 64-bit
// adder/subtractor for the difference (S_SUB) and then the accumulation
// (S_ADD). A command code of 3 skips the scan, and a word is not finished
// until the output register is free. in_tready is high only while the
// sequencer is idle. A finished result waits in the output register, so the
// next word may be accepted while it is still pending.
module task_runtime_accounting_table #(
  parameter int SLOTS        = 32,
  parameter int STATIC_TASKS = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0 up: task_id[15:0], next_task_id[31:16], timestamp[95:32].
  input  logic [trat_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0 up: cmd[1:0].
  input  logic [trat_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0 up: status[1:0], slot[6:2], runtime[70:7],
  // task_count[76:71], zero padding[79:77].
  output logic [trat_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int INIT_TASKS = (STATIC_TASKS < SLOTS) ? STATIC_TASKS : SLOTS;
  localparam int PAD_W = trat_pkg::OUT_DATA_W - trat_pkg::STATUS_W - trat_pkg::SLOT_W
                         - trat_pkg::TIME_W - trat_pkg::COUNT_W;

  trat_pkg::state_t state_r, state_nxt;

  // Latched command word.
  trat_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [trat_pkg::TASK_W-1:0]  id_r, id_nxt;
  logic [trat_pkg::TASK_W-1:0]  next_r, next_nxt;
  logic [trat_pkg::TIME_W-1:0]  ts_r, ts_nxt;

  // Scan state.
  logic [IW-1:0]                idx_r, idx_nxt;
  logic                         hits_r, hits_nxt;
  logic                         from_seen_r, from_seen_nxt;
  logic [trat_pkg::TIME_W-1:0]  acc_r, acc_nxt;

  // Result being built.
  trat_pkg::status_t            status_r, status_nxt;
  logic [IW-1:0]                slot_r, slot_nxt;
  logic [trat_pkg::TIME_W-1:0]  rt_r, rt_nxt;

  // Table state held in flops.
  logic [SLOTS-1:0]             valid_r, valid_nxt;
  logic [trat_pkg::COUNT_W-1:0] count_r, count_nxt;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [trat_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Slot memory port.
  logic             mem_we;
  trat_pkg::entry_t mem_wdata;
  trat_pkg::entry_t ent;

  // The shared adder/subtractor.
  logic [trat_pkg::TIME_W-1:0] add_a, add_b, add_sum;
  logic                        add_sub;

  // Per-slot decisions made in the compare cycle.
  logic v_cur, m_id, m_next, last_idx;
  logic free_hit, stop_hit, sw_id, sw_next;
  logic accept, out_free;

  trat_slot_mem #(
    .SLOTS (SLOTS)
  ) u_slot_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (ent)
  );

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + trat_pkg::TIME_W'(add_sub);

  // Operand select for the shared adder: the elapsed time is formed in S_SUB
  // and added to the stored run time in S_ADD.
  always_comb begin
    add_a   = ts_r;
    add_b   = ent.start;
    add_sub = 1'b1;
    if (state_r == trat_pkg::S_ADD) begin
      add_a   = ent.runtime;
      add_b   = acc_r;
      add_sub = 1'b0;
    end
  end

  assign in_tready  = (state_r == trat_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign v_cur    = valid_r[idx_r];
  assign m_id     = (ent.task_id == id_r);
  assign m_next   = (ent.task_id == next_r);
  assign last_idx = (idx_r == IW'(SLOTS - 1));

  // Start claims a free slot; stop and switch only ever look at valid slots.
  // On a switch the outgoing id has priority, so a slot whose id is both the
  // outgoing and the incoming task gets only the run time update.
  assign free_hit = (cmd_r == trat_pkg::CMD_START) && !v_cur;
  assign stop_hit = (cmd_r == trat_pkg::CMD_STOP) && v_cur && m_id;
  assign sw_id    = (cmd_r == trat_pkg::CMD_SWITCH) && v_cur && m_id;
  assign sw_next  = (cmd_r == trat_pkg::CMD_SWITCH) && v_cur && !m_id && m_next;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trat_pkg::S_IDLE: begin
        if (accept) begin
          if (in_tuser inside {trat_pkg::CMD_START, trat_pkg::CMD_STOP, trat_pkg::CMD_SWITCH}) begin
            state_nxt = trat_pkg::S_READ;
          end else begin
            state_nxt = trat_pkg::S_DONE;
          end
        end
      end
      trat_pkg::S_READ: begin
        state_nxt = trat_pkg::S_CHECK;
      end
      trat_pkg::S_CHECK: begin
        if (free_hit || stop_hit) begin
          state_nxt = trat_pkg::S_DONE;
        end else if (sw_id) begin
          state_nxt = trat_pkg::S_SUB;
        end else if ((sw_next && hits_r) || last_idx) begin
          state_nxt = trat_pkg::S_DONE;
        end else begin
          state_nxt = trat_pkg::S_READ;
        end
      end
      trat_pkg::S_SUB: begin
        state_nxt = trat_pkg::S_ADD;
      end
      trat_pkg::S_ADD: begin
        if (hits_r || last_idx) begin
          state_nxt = trat_pkg::S_DONE;
        end else begin
          state_nxt = trat_pkg::S_READ;
        end
      end
      trat_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = trat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = trat_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    next_nxt      = next_r;
    ts_nxt        = ts_r;
    idx_nxt       = idx_r;
    hits_nxt      = hits_r;
    from_seen_nxt = from_seen_r;
    acc_nxt       = acc_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    rt_nxt        = rt_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = ent;

    case (state_r)
      trat_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_tuser;
          id_nxt        = in_tdata[15:0];
          next_nxt      = in_tdata[31:16];
          ts_nxt        = in_tdata[95:32];
          idx_nxt       = (in_tuser == trat_pkg::CMD_SWITCH) ? '0 : IW'(1);
          hits_nxt      = 1'b0;
          from_seen_nxt = 1'b0;
          slot_nxt      = '0;
          rt_nxt        = '0;
          case (in_tuser)
            trat_pkg::CMD_START:  status_nxt = trat_pkg::ST_FULL;
            trat_pkg::CMD_STOP:   status_nxt = trat_pkg::ST_MISSING;
            trat_pkg::CMD_SWITCH: status_nxt = trat_pkg::ST_MISSING;
            default:              status_nxt = trat_pkg::ST_OK;
          endcase
        end
      end
      trat_pkg::S_CHECK: begin
        if (free_hit) begin
          mem_we             = 1'b1;
          mem_wdata.task_id  = id_r;
          mem_wdata.runtime  = '0;
          mem_wdata.start    = '0;
          valid_nxt[idx_r]   = 1'b1;
          count_nxt          = count_r + trat_pkg::COUNT_W'(1);
          status_nxt         = trat_pkg::ST_OK;
          slot_nxt           = idx_r;
        end else if (stop_hit) begin
          mem_we             = 1'b1;
          mem_wdata          = '0;
          valid_nxt[idx_r]   = 1'b0;
          count_nxt          = count_r - trat_pkg::COUNT_W'(1);
          status_nxt         = trat_pkg::ST_OK;
          slot_nxt           = idx_r;
        end else if (sw_next) begin
          mem_we             = 1'b1;
          mem_wdata.start    = ts_r;
          hits_nxt           = 1'b1;
        end
      end
      trat_pkg::S_SUB: begin
        // Elapsed time of the outgoing run.
        acc_nxt = add_sum;
      end
      trat_pkg::S_ADD: begin
        mem_we            = 1'b1;
        mem_wdata.runtime = add_sum;
        hits_nxt          = 1'b1;
        if (!from_seen_r) begin
          from_seen_nxt = 1'b1;
          status_nxt    = trat_pkg::ST_OK;
          slot_nxt      = idx_r;
          rt_nxt        = add_sum;
        end
      end
      trat_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {PAD_W'(0), count_r, rt_r, trat_pkg::SLOT_W'(slot_r), status_r};
        end
      end
      default: begin
      end
    endcase

    // Step to the next slot whenever the scan goes on.
    if (((state_r == trat_pkg::S_CHECK) || (state_r == trat_pkg::S_ADD)) &&
        (state_nxt == trat_pkg::S_READ)) begin
      idx_nxt = idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trat_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= trat_pkg::COUNT_W'(INIT_TASKS);
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i] <= (i < INIT_TASKS);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    next_r      <= next_nxt;
    ts_r        <= ts_nxt;
    idx_r       <= idx_nxt;
    hits_r      <= hits_nxt;
    from_seen_r <= from_seen_nxt;
    acc_r       <= acc_nxt;
    status_r    <= status_nxt;
    slot_r      <= slot_nxt;
    rt_r        <= rt_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

/* rtl/core/trat_checker.sv */
`include "task_runtime_accounting_table_defines.svh"

module trat_checker #(
  parameter int SLOTS = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [trat_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic in_acc;
  logic out_stall;
  logic out_fail;
  logic count_ok;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_fail  = out_tvalid && (out_tdata[1:0] != trat_pkg::ST_OK);
  assign count_ok  = (SLOTS > 63) || (int'(out_tdata[76:71]) <= SLOTS);

  // A result word that is not taken stays put.
  `TRAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata),
                    "result word changed while stalled")

  // The sequencer is still busy in the cycle after it takes a word.
  `TRAT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready,
                    "input taken again right after acceptance")

  // A failed command reports slot zero and zero run time.
  `TRAT_ASSERT_SAME(a_fail_zero, clk, rst_n, out_fail, out_tdata[70:2] == 69'd0,
                    "failed command carries a slot or run time")

  // The task count never exceeds the table size when it fits the field.
  `TRAT_ASSERT_SAME(a_count_bound, clk, rst_n, out_tvalid, count_ok,
                    "task count above table size")

endmodule

bind task_runtime_accounting_table trat_checker #(.SLOTS(SLOTS)) u_trat_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS        = 32;
  localparam int STATIC_TASKS = 2;

  // The command code the block leaves unused; it must answer without touching the table.
  localparam trat_pkg::cmd_t CMD_UNUSED = 2'd3;

  // How many random words follow the directed opening.
  localparam int RANDOM_WORDS = 1100;
  // The last words of the run are sent and taken with no idling at all.
  localparam int CALM_TAIL    = 150;
  // The receiver stops once for this many cycles, after this many words went in.
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AFTER   = 400;
  // Cycles to wait after the last expected result.
  localparam int DRAIN_CYCLES = 2 * SLOTS + 20;

  // One command word as it travels on the input channel.
  typedef struct packed {
    trat_pkg::cmd_t cmd;
    logic [15:0]    id;
    logic [15:0]    next;
    logic [63:0]    ts;
  } task_word_t;

  // One result word, field by field.
  typedef struct packed {
    trat_pkg::status_t status;
    logic [4:0]        slot;
    logic [63:0]       runtime;
    logic [5:0]        count;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;  // task_id[15:0], next_task_id[31:16], timestamp[95:32]
  logic [1:0]  in_tuser   = '0;  // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;        // status[1:0], slot[6:2], runtime[70:7], task_count[76:71]

  task_runtime_accounting_table #(
    .SLOTS       (SLOTS),
    .STATIC_TASKS(STATIC_TASKS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Our own copy of the slot table, updated as each word is accepted.
  logic        tbl_valid   [SLOTS];
  logic [15:0] tbl_task    [SLOTS];
  logic [63:0] tbl_runtime [SLOTS];
  logic [63:0] tbl_start   [SLOTS];
  logic [5:0]  live_count;

  task_word_t  pending_words[$];
  result_t     expected_results[$];

  int          total_words;
  int          words_accepted = 0;
  int          error_count    = 0;

  // Tallies for the closing summary.
  int          n_start, n_stop, n_switch, n_unused, n_full, n_missing;

  // Time base used by the scheduler-like part of the stimulus.
  logic [63:0] sched_clock;

  // Put the table in its reset state: the static tasks sit in the low slots with ids 0 upward.
  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]   = (i < STATIC_TASKS);
      tbl_task[i]    = (i < STATIC_TASKS) ? i[15:0] : 16'd0;
      tbl_runtime[i] = '0;
      tbl_start[i]   = '0;
    end
    live_count = (STATIC_TASKS < SLOTS) ? 6'(STATIC_TASKS) : 6'(SLOTS);
  endtask

  // Apply one accepted command word to the table and queue the result it should produce.
  task automatic account_word(input trat_pkg::cmd_t cmd, input logic [15:0] id,
                              input logic [15:0] next, input logic [63:0] ts);
    result_t r;
    int      i;
    int      hits;
    bit      from_seen;
    r         = '0;
    r.status  = trat_pkg::ST_OK;
    hits      = 0;
    from_seen = 1'b0;
    case (cmd)
      trat_pkg::CMD_START: begin
        // The first free slot from index 1 is claimed, even if the id is already present.
        n_start++;
        r.status = trat_pkg::ST_FULL;
        for (i = 1; i < SLOTS; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i]   = 1'b1;
            tbl_task[i]    = id;
            tbl_runtime[i] = '0;
            tbl_start[i]   = '0;
            live_count     = live_count + 6'd1;
            r.status       = trat_pkg::ST_OK;
            r.slot         = i[4:0];
            break;
          end
        end
        if (r.status == trat_pkg::ST_FULL) n_full++;
      end
      trat_pkg::CMD_STOP: begin
        // Slot 0 is never searched, so the task in it can never be stopped.
        n_stop++;
        r.status = trat_pkg::ST_MISSING;
        for (i = 1; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_task[i] == id) begin
            tbl_valid[i]   = 1'b0;
            tbl_task[i]    = '0;
            tbl_runtime[i] = '0;
            tbl_start[i]   = '0;
            live_count     = live_count - 6'd1;
            r.status       = trat_pkg::ST_OK;
            r.slot         = i[4:0];
            break;
          end
        end
        if (r.status == trat_pkg::ST_MISSING) n_missing++;
      end
      trat_pkg::CMD_SWITCH: begin
        // The outgoing match wins over the incoming one for a slot, and the scan stops at the
        // second match of either kind. The elapsed time wraps modulo 2^64.
        n_switch++;
        r.status = trat_pkg::ST_MISSING;
        for (i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i]) continue;
          if (tbl_task[i] == id) begin
            tbl_runtime[i] = tbl_runtime[i] + (ts - tbl_start[i]);
            if (!from_seen) begin
              from_seen = 1'b1;
              r.status  = trat_pkg::ST_OK;
              r.slot    = i[4:0];
              r.runtime = tbl_runtime[i];
            end
            hits++;
          end else if (tbl_task[i] == next) begin
            tbl_start[i] = ts;
            hits++;
          end
          if (hits == 2) break;
        end
        if (r.status == trat_pkg::ST_MISSING) n_missing++;
      end
      default: begin
        n_unused++;
      end
    endcase
    r.count = live_count;
    expected_results.push_back(r);
  endtask

  task automatic push_word(input trat_pkg::cmd_t cmd, input logic [15:0] id,
                           input logic [15:0] next, input logic [63:0] ts);
    task_word_t w;
    w.cmd  = cmd;
    w.id   = id;
    w.next = next;
    w.ts   = ts;
    pending_words.push_back(w);
  endtask

  // Ids come mostly from a small pool so that starts, stops and switches find each other;
  // now and then a full-range id shows up.
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 11));
  endfunction

  function automatic logic [63:0] any_time();
    return {$urandom, $urandom};
  endfunction

  // The scheduler clock mostly moves forward by small steps, with an occasional jump anywhere.
  function automatic logic [63:0] tick_clock();
    if ($urandom_range(0, 39) == 0) sched_clock = any_time();
    else sched_clock = sched_clock + $urandom_range(1, 5000);
    return sched_clock;
  endfunction

  // Build the whole stimulus: a directed opening, then random segments of several flavors.
  task automatic build_stimulus();
    int             kind;
    int             len;
    int             r;
    trat_pkg::cmd_t c;
    // Switch between the two static tasks, then back.
    push_word(trat_pkg::CMD_SWITCH, 16'd0, 16'd1, 64'd100);
    push_word(trat_pkg::CMD_SWITCH, 16'd1, 16'd0, 64'd250);
    // Stopping the task in slot 0 never succeeds; an absent id is not found either.
    push_word(trat_pkg::CMD_STOP, 16'd0, 16'd0, 64'd0);
    push_word(trat_pkg::CMD_STOP, 16'h1234, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // The same id started twice takes two slots.
    push_word(trat_pkg::CMD_START, 16'hFFFF, 16'd0, 64'd0);
    push_word(trat_pkg::CMD_START, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // The incoming task sits in slot 0 and is found first, so only the first outgoing slot is updated.
    push_word(trat_pkg::CMD_SWITCH, 16'hFFFF, 16'd0, 64'd1000);
    push_word(trat_pkg::CMD_STOP, 16'hFFFF, 16'd0, 64'd0);
    push_word(trat_pkg::CMD_START, 16'd5, 16'd0, 64'd0);
    // Outgoing and incoming the same: only the run time moves.
    push_word(trat_pkg::CMD_SWITCH, 16'd5, 16'd5, 64'd2000);
    push_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_word(CMD_UNUSED, 16'd0, 16'd0, 64'd0);
    // Largest timestamp, then a timestamp below the start time so the difference wraps.
    push_word(trat_pkg::CMD_SWITCH, 16'd1, 16'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    push_word(trat_pkg::CMD_SWITCH, 16'd0, 16'd1, 64'd0);
    push_word(trat_pkg::CMD_SWITCH, 16'd1, 16'd0, 64'd3);
    // Outgoing task absent: not found, yet the incoming start time is still written.
    push_word(trat_pkg::CMD_SWITCH, 16'h4321, 16'd1, 64'h8000_0000_0000_0000);
    push_word(trat_pkg::CMD_SWITCH, 16'd1, 16'd5, 64'h8000_0000_0000_0010);
    push_word(trat_pkg::CMD_SWITCH, 16'hAAAA, 16'h5555, 64'hAAAA_AAAA_5555_5555);
    push_word(trat_pkg::CMD_STOP, 16'd5, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_word(trat_pkg::CMD_START, 16'h8000, 16'h7FFF, 64'h5555_5555_AAAA_AAAA);

    sched_clock = 64'd10_000;
    while (pending_words.size() < RANDOM_WORDS + 20) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        // Scheduler traffic: switches on a forward-moving clock.
        len = $urandom_range(20, 60);
        repeat (len) push_word(trat_pkg::CMD_SWITCH, pick_id(), pick_id(), tick_clock());
      end else if (kind <= 4) begin
        // Tasks being created, with switches in between.
        len = $urandom_range(10, 40);
        repeat (len) begin
          if ($urandom_range(0, 3) != 0)
            push_word(trat_pkg::CMD_START, pick_id(), 16'($urandom), any_time());
          else
            push_word(trat_pkg::CMD_SWITCH, pick_id(), pick_id(), tick_clock());
        end
      end else if (kind <= 6) begin
        // Tasks going away, with switches in between.
        len = $urandom_range(10, 35);
        repeat (len) begin
          if ($urandom_range(0, 3) != 0)
            push_word(trat_pkg::CMD_STOP, pick_id(), 16'($urandom), any_time());
          else
            push_word(trat_pkg::CMD_SWITCH, pick_id(), pick_id(), tick_clock());
        end
      end else if (kind == 7) begin
        // A flood of starts that runs the table full and keeps knocking on it.
        repeat (SLOTS + 8)
          push_word(trat_pkg::CMD_START, pick_id(), 16'($urandom), any_time());
      end else if (kind == 8) begin
        // Noise: every field random over its whole range, the unused command included.
        len = $urandom_range(5, 15);
        repeat (len) begin
          c = trat_pkg::cmd_t'($urandom_range(0, 3));
          push_word(c, 16'($urandom), 16'($urandom), any_time());
        end
      end else begin
        // An even mix of the three real commands.
        len = $urandom_range(20, 50);
        repeat (len) begin
          r = $urandom_range(0, 2);
          if (r == 0)
            push_word(trat_pkg::CMD_START, pick_id(), 16'($urandom), any_time());
          else if (r == 1)
            push_word(trat_pkg::CMD_STOP, pick_id(), 16'($urandom), any_time());
          else
            push_word(trat_pkg::CMD_SWITCH, pick_id(), pick_id(), tick_clock());
        end
      end
    end
  endtask

  // Sender. The word on the bus is held until it is taken; after a word is taken the driver
  // may pause for a random burst. How often it pauses changes every 64 words, including
  // stretches with no pauses at all, and the tail of the run has none.
  int         tx_gap      = 0;
  int         tx_idle_pct = 0;
  task_word_t tx_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        account_word(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[95:32]);
        words_accepted <= words_accepted + 1;
        if (words_accepted % 64 == 0) begin
          case ($urandom_range(0, 3))
            0, 1:    tx_idle_pct = 0;
            2:       tx_idle_pct = 12;
            default: tx_idle_pct = 35;
          endcase
        end
        if (words_accepted < total_words - CALM_TAIL && $urandom_range(0, 99) < tx_idle_pct)
          tx_gap = $urandom_range(1, 17);
      end
      if (in_tvalid && !in_tready) begin
        // Still waiting for the block to take the current word.
      end else if (tx_gap > 0) begin
        in_tvalid <= 1'b0;
        tx_gap--;
      end else if (pending_words.size() > 0) begin
        tx_word   = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= tx_word.cmd;
        in_tdata  <= {tx_word.ts, tx_word.next, tx_word.id};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. Random bursts of back-pressure of changing density, and once a long
  // hold-off so that the block fills its output register and stalls its input while
  // the sender keeps offering words.
  int rx_gap       = 0;
  int rx_idle_pct  = 0;
  int rx_phase     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_phase++;
      if (rx_phase % 200 == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    rx_idle_pct = 0;
          2:       rx_idle_pct = 10;
          default: rx_idle_pct = 35;
        endcase
      end
      if (!hold_done && words_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        out_tready <= 1'b0;
        rx_gap--;
      end else if (words_accepted < total_words - CALM_TAIL &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        out_tready <= 1'b0;
        rx_gap = $urandom_range(1, 17) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker: each word taken from the block is compared field by field with the
  // oldest expectation.
  result_t want;
  result_t got;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tdata[1:0];
      got.slot    = out_tdata[6:2];
      got.runtime = out_tdata[70:7];
      got.count   = out_tdata[76:71];
      if (expected_results.size() == 0) begin
        $display("%0t: result word %h arrived with nothing expected", $time, out_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
          error_count++;
        end
        if (got.runtime !== want.runtime) begin
          $display("%0t: runtime expected %h, got %h", $time, want.runtime, got.runtime);
          error_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: task_count expected %0d, got %0d", $time, want.count, got.count);
          error_count++;
        end
      end
    end
  end

  // Main sequence: build the stimulus, hold reset, then wait for every word to go in and
  // every result to come back before judging the run.
  initial begin
    n_start   = 0;
    n_stop    = 0;
    n_switch  = 0;
    n_unused  = 0;
    n_full    = 0;
    n_missing = 0;
    clear_table();
    build_stimulus();
    total_words = pending_words.size();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words: %0d starts (%0d on a full table), %0d stops, %0d switches,",
             words_accepted, n_start, n_full, n_stop, n_switch);
    $display("%0d unused commands; %0d stops or switches found no task; %0d mismatches.",
             n_unused, n_missing, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results still expected.", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
